// ===== rtl/hsec_pkg.sv =====
// ----------------------------------------------------------------------------
// hsec_pkg
// Types, codes and helper functions shared by the Hamming SEC encoder/decoder.
// ----------------------------------------------------------------------------
package hsec_pkg;

	localparam int WORD_W = 64;
	localparam int SYN_W  = 7;
	localparam int LEN_W  = 6;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [1:0] STAT_CLEAN     = 2'd0;
	localparam logic [1:0] STAT_CORRECTED = 2'd1;
	localparam logic [1:0] STAT_RANGE     = 2'd2;

	localparam logic [LEN_W-1:0] DATA_LEN_RESET = 6'd57;

	typedef struct packed {
		logic              mode;
		logic [WORD_W-1:0] word;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic [1:0]        status;
		logic [SYN_W-1:0]  syndrome;
	} out_t;

	// smallest r with 2^r >= k + r + 1
	function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] k);
		logic [2:0] r;
		r = 3'd6;
		for (int i = 6; i >= 0; i--) begin
			if ((8'd1 << i) >= ({2'b00, k} + 8'(i) + 8'd1)) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// clamp a written length to 1 .. max_k
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v,
		input logic [LEN_W-1:0] max_k);
		logic [LEN_W-1:0] k;
		k = v;
		if (k == '0) begin
			k = 6'd1;
		end
		if (k > max_k) begin
			k = max_k;
		end
		return k;
	endfunction

	function automatic bit is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// data bit index held at codeword position p (p not a power of two)
	function automatic int data_index(input int p);
		int cnt;
		cnt = 0;
		for (int q = 1; q < p; q++) begin
			if (!is_pow2(q)) begin
				cnt++;
			end
		end
		return cnt;
	endfunction

	// codeword position (1-based) of data bit d
	function automatic int data_pos(input int d);
		int p;
		int cnt;
		p = 0;
		cnt = -1;
		while (cnt < d) begin
			p++;
			if (!is_pow2(p)) begin
				cnt++;
			end
		end
		return p;
	endfunction

	// positions covered by syndrome bit i
	function automatic logic [WORD_W-1:0] pos_mask(input int i);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W - 1; b++) begin
			m[b] = 1'(((b + 1) >> i) & 1);
		end
		return m;
	endfunction

endpackage

// ===== rtl/hsec_core.sv =====
// ----------------------------------------------------------------------------
// hsec_core
// Single-pass encode or decode of one word: scatter, parity trees, correction.
// ----------------------------------------------------------------------------
module hsec_core import hsec_pkg::*; #(
	parameter int MAX_DATA_BITS = 57
) (
	input  logic [LEN_W-1:0] k,
	input  logic [LEN_W-1:0] n,
	input  in_t              item,
	output out_t             result
);

	logic [WORD_W-1:0] kmask;
	logic [WORD_W-1:0] nmask;
	logic [WORD_W-1:0] flip;
	logic [WORD_W-1:0] data_m;
	logic [WORD_W-1:0] scat;
	logic [WORD_W-1:0] enc_word;
	logic [WORD_W-1:0] cw_m;
	logic [WORD_W-1:0] cw_fix;
	logic [WORD_W-1:0] dec_data;
	logic [SYN_W-1:0]  syn_enc;
	logic [SYN_W-1:0]  syn_dec;
	logic              fix_ok;

	genvar b;
	genvar i;

	generate
		for (b = 0; b < WORD_W; b++) begin : g_bit
			assign kmask[b] = 7'(b) < {1'b0, k};
			assign nmask[b] = 7'(b) < {1'b0, n};
			assign flip[b]  = syn_dec == 7'(b + 1);

			if (!is_pow2(b + 1) && (data_index(b + 1) < MAX_DATA_BITS)) begin : g_scat
				assign scat[b] = data_m[data_index(b + 1)];
			end else begin : g_noscat
				assign scat[b] = 1'b0;
			end

			if (is_pow2(b + 1)) begin : g_par
				assign enc_word[b] = syn_enc[$clog2(b + 1)];
			end else begin : g_dat
				assign enc_word[b] = scat[b];
			end

			if (b < MAX_DATA_BITS) begin : g_ext
				assign dec_data[b] = cw_fix[data_pos(b) - 1];
			end else begin : g_noext
				assign dec_data[b] = 1'b0;
			end
		end

		for (i = 0; i < SYN_W; i++) begin : g_syn
			assign syn_enc[i] = ^(scat & pos_mask(i));
			assign syn_dec[i] = ^(cw_m & pos_mask(i));
		end
	endgenerate

	assign data_m = item.word & kmask;
	assign cw_m   = item.word & nmask;
	assign fix_ok = (syn_dec != '0) && (syn_dec <= {1'b0, n});
	assign cw_fix = fix_ok ? (cw_m ^ flip) : cw_m;

	always_comb begin
		result = '0;
		if (item.mode == MODE_ENCODE) begin
			result.result_word = enc_word;
			result.status      = STAT_CLEAN;
			result.syndrome    = '0;
		end else begin
			result.result_word = dec_data;
			result.syndrome    = syn_dec;
			if (syn_dec == '0) begin
				result.status = STAT_CLEAN;
			end else if (fix_ok) begin
				result.status = STAT_CORRECTED;
			end else begin
				result.status = STAT_RANGE;
			end
		end
	end

endmodule

// ===== rtl/hamming_sec_encode_decode.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_encode_decode
// Hamming single-error-correcting encoder/decoder with a configurable length.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. Each word is captured in an input
// register, encoded or decoded combinationally by xor trees and muxes, and
// held in a result register that drives the output; a new word is taken
// every cycle while the output side is not stalled. cfg_wdata sets the data
// length k (0 reads as 1, values above MAX_DATA_BITS saturate); the codeword
// is k plus the smallest parity count r with 2^r >= k+r+1. Write the length
// only while no transaction is in flight.
module hamming_sec_encode_decode import hsec_pkg::*; #(
	parameter int MAX_DATA_BITS = 57
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data
);

	localparam logic [LEN_W-1:0] MAX_K = LEN_W'(MAX_DATA_BITS);
	localparam logic [LEN_W-1:0] K_RST = eff_len(DATA_LEN_RESET, MAX_K);
	localparam logic [LEN_W-1:0] N_RST = K_RST + LEN_W'(parity_count(K_RST));

	logic [LEN_W-1:0] k_q;
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] k_d;
	logic             valid_s1;
	in_t              item_s1;
	logic             valid_s2;
	out_t             res_s2;
	out_t             res_d;
	logic             s2_ready;
	logic             s1_ready;

	assign k_d = eff_len(cfg_wdata, MAX_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_RST;
			n_q <= N_RST;
		end else if (cfg_we) begin
			k_q <= k_d;
			n_q <= k_d + LEN_W'(parity_count(k_d));
		end
	end

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (s2_ready && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	hsec_core #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_core (
		.k      (k_q),
		.n      (n_q),
		.item   (item_s1),
		.result (res_d)
	);

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input stage");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q >= 6'd1) && (k_q <= MAX_K) && (n_q > k_q))
		else $error("data length register out of range");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transaction lost");

	a_range_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_RANGE) |-> out_data.syndrome > {1'b0, n_q})
		else $error("out-of-range status with syndrome inside codeword");

	a_clean_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.syndrome != '0) |-> out_data.status != STAT_CLEAN)
		else $error("nonzero syndrome reported as clean");
`endif

endmodule
